@@ src/cpu8_pkg.sv @@
package cpu8_pkg;

  localparam int MEM_DEPTH = 65536;

  // request codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;
  localparam logic [1:0] CMD_RESET = 2'd3;

  localparam logic [15:0] VEC_RESET_LO = 16'hFFFC;
  localparam logic [15:0] VEC_RESET_HI = 16'hFFFD;
  localparam logic [7:0]  STACK_PAGE   = 8'h01;
  localparam logic [7:0]  SP_INIT      = 8'hFD;
  localparam logic [7:0]  P_MASK       = 8'hCF;
  localparam logic [7:0]  P_BRK_BITS   = 8'h30;

  localparam int PF_N = 7;
  localparam int PF_V = 6;
  localparam int PF_D = 3;
  localparam int PF_I = 2;
  localparam int PF_Z = 1;
  localparam int PF_C = 0;

  typedef enum logic [3:0] {
    AM_IMP, AM_IMM, AM_ZP, AM_ZPX, AM_ABS, AM_ABSX, AM_ABSY, AM_INDX, AM_INDY, AM_REL
  } amode_t;

  typedef enum logic [3:0] {
    CL_IMP, CL_READ, CL_STORE, CL_RMW, CL_PUSH, CL_PULL, CL_JSR, CL_RTS, CL_RTI,
    CL_JMP, CL_JMPI, CL_BR, CL_BAD
  } cls_t;

  typedef enum logic [5:0] {
    OP_NOP, OP_BIT, OP_TAX, OP_TXA, OP_DEX, OP_INX, OP_TAY, OP_TYA, OP_DEY, OP_INY,
    OP_INC, OP_DEC, OP_AND, OP_ORA, OP_ASLA, OP_ASL, OP_ROL, OP_ADC, OP_SBC,
    OP_TXS, OP_TSX, OP_PHA, OP_PLA, OP_PHP, OP_PLP, OP_BR, OP_CMP, OP_CPX, OP_CPY,
    OP_LDA, OP_LDX, OP_LDY, OP_STA, OP_STX, OP_STY,
    OP_CLC, OP_SEC, OP_CLI, OP_SEI, OP_CLV, OP_CLD, OP_SED
  } aluop_t;

  typedef struct packed {
    amode_t mode;
    cls_t   cls;
    aluop_t op;
  } dec_t;

  typedef enum logic [2:0] {
    AS_PC, AS_EA, AS_EA_NEXT, AS_STK, AS_HOST, AS_VEC_LO, AS_VEC_HI
  } asel_t;

  typedef enum logic [2:0] {
    WS_HOST, WS_STORE, WS_PUSH, WS_RES, WS_PCH, WS_PCL
  } wsel_t;

  typedef enum logic [2:0] {
    PC_KEEP, PC_INC, PC_LOHI, PC_LOHI_INC, PC_EA
  } pcop_t;

  typedef enum logic [2:0] {
    EA_KEEP, EA_LO, EA_ZP, EA_ZPX, EA_ABS, EA_ABSX, EA_ABSY
  } eaop_t;

  typedef enum logic [1:0] {
    SP_KEEP, SP_INC, SP_DEC, SP_RESET
  } spop_t;

  // controller -> datapath
  typedef struct packed {
    asel_t asel;
    logic  mem_we;
    wsel_t wsel;
    pcop_t pc_op;
    eaop_t ea_op;
    spop_t sp_op;
    logic  op_load;
    logic  exec;
    logic  host_load;
    logic  rdb_clr;
    logic  rdb_load;
    logic  vec_rst;
    logic  out_load;
    logic  bad_opc;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    amode_t mode;
    cls_t   cls;
  } ctl_stat_t;

  function automatic dec_t decode(input logic [7:0] opc);
    dec_t d;
    d = '{AM_IMP, CL_BAD, OP_NOP};
    unique case (opc)
      8'h24: d = '{AM_ZP,   CL_READ,  OP_BIT};
      8'h2C: d = '{AM_ABS,  CL_READ,  OP_BIT};
      8'hEA: d = '{AM_IMP,  CL_IMP,   OP_NOP};
      8'hAA: d = '{AM_IMP,  CL_IMP,   OP_TAX};
      8'h8A: d = '{AM_IMP,  CL_IMP,   OP_TXA};
      8'hCA: d = '{AM_IMP,  CL_IMP,   OP_DEX};
      8'hE8: d = '{AM_IMP,  CL_IMP,   OP_INX};
      8'hA8: d = '{AM_IMP,  CL_IMP,   OP_TAY};
      8'h98: d = '{AM_IMP,  CL_IMP,   OP_TYA};
      8'h88: d = '{AM_IMP,  CL_IMP,   OP_DEY};
      8'hC8: d = '{AM_IMP,  CL_IMP,   OP_INY};
      8'hE6: d = '{AM_ZP,   CL_RMW,   OP_INC};
      8'hF6: d = '{AM_ZPX,  CL_RMW,   OP_INC};
      8'hEE: d = '{AM_ABS,  CL_RMW,   OP_INC};
      8'hFE: d = '{AM_ABSX, CL_RMW,   OP_INC};
      8'hC6: d = '{AM_ZP,   CL_RMW,   OP_DEC};
      8'hD6: d = '{AM_ZPX,  CL_RMW,   OP_DEC};
      8'hCE: d = '{AM_ABS,  CL_RMW,   OP_DEC};
      8'hDE: d = '{AM_ABSX, CL_RMW,   OP_DEC};
      8'h29: d = '{AM_IMM,  CL_READ,  OP_AND};
      8'h25: d = '{AM_ZP,   CL_READ,  OP_AND};
      8'h09: d = '{AM_IMM,  CL_READ,  OP_ORA};
      8'h05: d = '{AM_ZP,   CL_READ,  OP_ORA};
      8'h0D: d = '{AM_ABS,  CL_READ,  OP_ORA};
      8'h0A: d = '{AM_IMP,  CL_IMP,   OP_ASLA};
      8'h06: d = '{AM_ZP,   CL_RMW,   OP_ASL};
      8'h26: d = '{AM_ZP,   CL_RMW,   OP_ROL};
      8'h69: d = '{AM_IMM,  CL_READ,  OP_ADC};
      8'h65: d = '{AM_ZP,   CL_READ,  OP_ADC};
      8'h75: d = '{AM_ZPX,  CL_READ,  OP_ADC};
      8'h6D: d = '{AM_ABS,  CL_READ,  OP_ADC};
      8'h7D: d = '{AM_ABSX, CL_READ,  OP_ADC};
      8'h79: d = '{AM_ABSY, CL_READ,  OP_ADC};
      8'h61: d = '{AM_INDX, CL_READ,  OP_ADC};
      8'h71: d = '{AM_INDY, CL_READ,  OP_ADC};
      8'hE9: d = '{AM_IMM,  CL_READ,  OP_SBC};
      8'hE5: d = '{AM_ZP,   CL_READ,  OP_SBC};
      8'hE1: d = '{AM_INDX, CL_READ,  OP_SBC};
      8'hF1: d = '{AM_INDY, CL_READ,  OP_SBC};
      8'h9A: d = '{AM_IMP,  CL_IMP,   OP_TXS};
      8'hBA: d = '{AM_IMP,  CL_IMP,   OP_TSX};
      8'h48: d = '{AM_IMP,  CL_PUSH,  OP_PHA};
      8'h68: d = '{AM_IMP,  CL_PULL,  OP_PLA};
      8'h08: d = '{AM_IMP,  CL_PUSH,  OP_PHP};
      8'h28: d = '{AM_IMP,  CL_PULL,  OP_PLP};
      8'h20: d = '{AM_ABS,  CL_JSR,   OP_NOP};
      8'h60: d = '{AM_IMP,  CL_RTS,   OP_NOP};
      8'h40: d = '{AM_IMP,  CL_RTI,   OP_PLP};
      8'h4C: d = '{AM_ABS,  CL_JMP,   OP_NOP};
      8'h6C: d = '{AM_ABS,  CL_JMPI,  OP_NOP};
      8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hB0, 8'hD0, 8'hF0:
             d = '{AM_REL,  CL_BR,    OP_BR};
      8'hC9: d = '{AM_IMM,  CL_READ,  OP_CMP};
      8'hC5: d = '{AM_ZP,   CL_READ,  OP_CMP};
      8'hCD: d = '{AM_ABS,  CL_READ,  OP_CMP};
      8'hE0: d = '{AM_IMM,  CL_READ,  OP_CPX};
      8'hC0: d = '{AM_IMM,  CL_READ,  OP_CPY};
      8'hA9: d = '{AM_IMM,  CL_READ,  OP_LDA};
      8'hA5: d = '{AM_ZP,   CL_READ,  OP_LDA};
      8'hB5: d = '{AM_ZPX,  CL_READ,  OP_LDA};
      8'hAD: d = '{AM_ABS,  CL_READ,  OP_LDA};
      8'hBD: d = '{AM_ABSX, CL_READ,  OP_LDA};
      8'hB9: d = '{AM_ABSY, CL_READ,  OP_LDA};
      8'hA1: d = '{AM_INDX, CL_READ,  OP_LDA};
      8'hB1: d = '{AM_INDY, CL_READ,  OP_LDA};
      8'hA2: d = '{AM_IMM,  CL_READ,  OP_LDX};
      8'hA6: d = '{AM_ZP,   CL_READ,  OP_LDX};
      8'hA0: d = '{AM_IMM,  CL_READ,  OP_LDY};
      8'hA4: d = '{AM_ZP,   CL_READ,  OP_LDY};
      8'h85: d = '{AM_ZP,   CL_STORE, OP_STA};
      8'h95: d = '{AM_ZPX,  CL_STORE, OP_STA};
      8'h8D: d = '{AM_ABS,  CL_STORE, OP_STA};
      8'h9D: d = '{AM_ABSX, CL_STORE, OP_STA};
      8'h99: d = '{AM_ABSY, CL_STORE, OP_STA};
      8'h81: d = '{AM_INDX, CL_STORE, OP_STA};
      8'h91: d = '{AM_INDY, CL_STORE, OP_STA};
      8'h86: d = '{AM_ZP,   CL_STORE, OP_STX};
      8'h8E: d = '{AM_ABS,  CL_STORE, OP_STX};
      8'h84: d = '{AM_ZP,   CL_STORE, OP_STY};
      8'h18: d = '{AM_IMP,  CL_IMP,   OP_CLC};
      8'h38: d = '{AM_IMP,  CL_IMP,   OP_SEC};
      8'h58: d = '{AM_IMP,  CL_IMP,   OP_CLI};
      8'h78: d = '{AM_IMP,  CL_IMP,   OP_SEI};
      8'hB8: d = '{AM_IMP,  CL_IMP,   OP_CLV};
      8'hD8: d = '{AM_IMP,  CL_IMP,   OP_CLD};
      8'hF8: d = '{AM_IMP,  CL_IMP,   OP_SED};
      default: d = '{AM_IMP, CL_BAD, OP_NOP};
    endcase
    return d;
  endfunction

endpackage

@@ src/cpu_8bit_instruction_core.sv @@
// Channel  | Ports                                         | Direction
// ---------+-----------------------------------------------+----------
// request  | in_valid, in_stall, in_command, in_host_addr, | in
//          | in_host_data                                  |
// result   | out_valid, out_stall, out_read_data,          | out
//          | out_pc_value, out_acc, out_x_reg, out_y_reg,  |
//          | out_stack_ptr, out_status_flags, out_bad_opcode|
//
// One request at a time; a host write, a host read, a processor reset and a step
// each walk their own sequence of controller states, and a step's sequence
// depends on its addressing mode and class. Every access goes through the
// single-port memory, whose read is registered.
// rst_n is synchronous: architectural registers clear, SP goes to 0xFD, memory keeps data.
// A finished result waits in the output register under out_stall while the
// next request is already accepted and worked on.
module cpu_8bit_instruction_core #(
  parameter int MEM_DEPTH = cpu8_pkg::MEM_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_host_addr,
  input  logic [7:0]  in_host_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic [15:0] out_pc_value,
  output logic [7:0]  out_acc,
  output logic [7:0]  out_x_reg,
  output logic [7:0]  out_y_reg,
  output logic [7:0]  out_stack_ptr,
  output logic [7:0]  out_status_flags,
  output logic        out_bad_opcode
);
  import cpu8_pkg::*;

  localparam int AW = $clog2(MEM_DEPTH);

  ctl_cmd_t    cmd;
  ctl_stat_t   stat;
  logic [15:0] mem_addr;
  logic        mem_we;
  logic [7:0]  mem_wdata, mem_rdata;

  // sequencer: walks the fetch / address / data steps of each request
  cpu8_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  // registers, ALU, address generation and result register
  cpu8_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_host_addr     (in_host_addr),
    .in_host_data     (in_host_data),
    .mem_addr         (mem_addr),
    .mem_we           (mem_we),
    .mem_wdata        (mem_wdata),
    .mem_rdata        (mem_rdata),
    .out_read_data    (out_read_data),
    .out_pc_value     (out_pc_value),
    .out_acc          (out_acc),
    .out_x_reg        (out_x_reg),
    .out_y_reg        (out_y_reg),
    .out_stack_ptr    (out_stack_ptr),
    .out_status_flags (out_status_flags),
    .out_bad_opcode   (out_bad_opcode)
  );

  // main memory, one port, registered read
  cpu8_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .addr    (mem_addr[AW-1:0]),
    .wr_data (mem_wdata),
    .rd_data (mem_rdata)
  );

endmodule

@@ src/cpu8_ram.sv @@
module cpu8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wr_data,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wr_data;
    end
    rdata_r <= mem[addr];
  end

  assign rd_data = rdata_r;

endmodule

@@ src/cpu8_dp.sv @@
module cpu8_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  cpu8_pkg::ctl_cmd_t  cmd,
  output cpu8_pkg::ctl_stat_t stat,
  input  logic [15:0]         in_host_addr,
  input  logic [7:0]          in_host_data,
  output logic [15:0]         mem_addr,
  output logic                mem_we,
  output logic [7:0]          mem_wdata,
  input  logic [7:0]          mem_rdata,
  output logic [7:0]          out_read_data,
  output logic [15:0]         out_pc_value,
  output logic [7:0]          out_acc,
  output logic [7:0]          out_x_reg,
  output logic [7:0]          out_y_reg,
  output logic [7:0]          out_stack_ptr,
  output logic [7:0]          out_status_flags,
  output logic                out_bad_opcode
);
  import cpu8_pkg::*;

  logic [15:0] pc_r, pc_nxt, ea_r, ea_nxt, host_addr_r;
  logic [7:0]  a_r, a_nxt, x_r, x_nxt, y_r, y_nxt, sp_r, sp_nxt, p_r, p_nxt;
  logic [7:0]  op_r, lo_r, res_r, res_nxt, rdb_r, host_data_r;
  logic [7:0]  addend, cmp_src, m;
  logic [8:0]  sum9, diff9;
  logic [15:0] pcm1;
  logic        br_flag, br_taken;
  dec_t        dec;

  logic [7:0]  o_rd_r, o_a_r, o_x_r, o_y_r, o_sp_r, o_p_r;
  logic [15:0] o_pc_r;
  logic        o_bad_r;

  function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] q;
    q = p;
    q[PF_N] = v[7];
    q[PF_Z] = (v == 8'h00);
    return q;
  endfunction

  assign dec  = decode(op_r);
  assign stat = '{dec.mode, dec.cls};
  assign m    = mem_rdata;
  assign pcm1 = pc_r - 16'd1;

  // memory port
  always_comb begin
    unique case (cmd.asel)
      AS_PC:      mem_addr = pc_r;
      AS_EA:      mem_addr = ea_r;
      AS_EA_NEXT: mem_addr = {ea_r[15:8], ea_r[7:0] + 8'd1};
      AS_STK:     mem_addr = {STACK_PAGE, sp_r};
      AS_HOST:    mem_addr = host_addr_r;
      AS_VEC_LO:  mem_addr = VEC_RESET_LO;
      AS_VEC_HI:  mem_addr = VEC_RESET_HI;
      default:    mem_addr = pc_r;
    endcase
    unique case (cmd.wsel)
      WS_HOST:  mem_wdata = host_data_r;
      WS_STORE: mem_wdata = (dec.op == OP_STX) ? x_r : ((dec.op == OP_STY) ? y_r : a_r);
      WS_PUSH:  mem_wdata = (dec.op == OP_PHP) ? (p_r | P_BRK_BITS) : a_r;
      WS_RES:   mem_wdata = res_r;
      WS_PCH:   mem_wdata = pcm1[15:8];
      WS_PCL:   mem_wdata = pcm1[7:0];
      default:  mem_wdata = a_r;
    endcase
  end
  assign mem_we = cmd.mem_we;

  // ALU
  assign addend  = (dec.op == OP_SBC) ? ~m : m;
  assign sum9    = {1'b0, a_r} + {1'b0, addend} + {8'd0, p_r[PF_C]};
  assign cmp_src = (dec.op == OP_CPX) ? x_r : ((dec.op == OP_CPY) ? y_r : a_r);
  assign diff9   = {1'b0, cmp_src} + {1'b0, ~m} + 9'd1;

  // branch condition: opcode bits 7:6 pick the flag, bit 5 the sense
  always_comb begin
    unique case (op_r[7:6])
      2'b00:   br_flag = p_r[PF_N];
      2'b01:   br_flag = p_r[PF_V];
      2'b10:   br_flag = p_r[PF_C];
      default: br_flag = p_r[PF_Z];
    endcase
  end
  assign br_taken = (br_flag == op_r[5]);

  always_comb begin
    a_nxt   = a_r;
    x_nxt   = x_r;
    y_nxt   = y_r;
    p_nxt   = p_r;
    res_nxt = res_r;
    pc_nxt  = pc_r;
    sp_nxt  = sp_r;
    ea_nxt  = ea_r;

    unique case (cmd.pc_op)
      PC_KEEP:     pc_nxt = pc_r;
      PC_INC:      pc_nxt = pc_r + 16'd1;
      PC_LOHI:     pc_nxt = {m, lo_r};
      PC_LOHI_INC: pc_nxt = {m, lo_r} + 16'd1;
      PC_EA:       pc_nxt = ea_r;
      default:     pc_nxt = pc_r;
    endcase

    unique case (cmd.sp_op)
      SP_KEEP:  sp_nxt = sp_r;
      SP_INC:   sp_nxt = sp_r + 8'd1;
      SP_DEC:   sp_nxt = sp_r - 8'd1;
      SP_RESET: sp_nxt = SP_INIT;
      default:  sp_nxt = sp_r;
    endcase

    unique case (cmd.ea_op)
      EA_ZP:   ea_nxt = {8'h00, m};
      EA_ZPX:  ea_nxt = {8'h00, m + x_r};
      EA_ABS:  ea_nxt = {m, lo_r};
      EA_ABSX: ea_nxt = {m, lo_r} + {8'h00, x_r};
      EA_ABSY: ea_nxt = {m, lo_r} + {8'h00, y_r};
      default: ea_nxt = ea_r;
    endcase

    if (cmd.vec_rst) begin
      p_nxt = 8'h00;
    end

    if (cmd.exec) begin
      unique case (dec.op)
        OP_BIT: begin
          p_nxt[PF_N] = m[7];
          p_nxt[PF_V] = m[6];
          p_nxt[PF_Z] = ((a_r & m) == 8'h00);
        end
        OP_TAX: begin x_nxt = a_r;         p_nxt = set_nz(p_r, a_r); end
        OP_TXA: begin a_nxt = x_r;         p_nxt = set_nz(p_r, x_r); end
        OP_DEX: begin x_nxt = x_r - 8'd1;  p_nxt = set_nz(p_r, x_r - 8'd1); end
        OP_INX: begin x_nxt = x_r + 8'd1;  p_nxt = set_nz(p_r, x_r + 8'd1); end
        OP_TAY: begin y_nxt = a_r;         p_nxt = set_nz(p_r, a_r); end
        OP_TYA: begin a_nxt = y_r;         p_nxt = set_nz(p_r, y_r); end
        OP_DEY: begin y_nxt = y_r - 8'd1;  p_nxt = set_nz(p_r, y_r - 8'd1); end
        OP_INY: begin y_nxt = y_r + 8'd1;  p_nxt = set_nz(p_r, y_r + 8'd1); end
        OP_INC: begin res_nxt = m + 8'd1;  p_nxt = set_nz(p_r, m + 8'd1); end
        OP_DEC: begin res_nxt = m - 8'd1;  p_nxt = set_nz(p_r, m - 8'd1); end
        OP_AND: begin a_nxt = a_r & m;     p_nxt = set_nz(p_r, a_r & m); end
        OP_ORA: begin a_nxt = a_r | m;     p_nxt = set_nz(p_r, a_r | m); end
        OP_ASLA: begin
          a_nxt = {a_r[6:0], 1'b0};
          p_nxt = set_nz(p_r, {a_r[6:0], 1'b0});
          p_nxt[PF_C] = a_r[7];
        end
        OP_ASL: begin
          res_nxt = {m[6:0], 1'b0};
          p_nxt = set_nz(p_r, {m[6:0], 1'b0});
          p_nxt[PF_C] = m[7];
        end
        OP_ROL: begin
          res_nxt = {m[6:0], p_r[PF_C]};
          p_nxt = set_nz(p_r, {m[6:0], p_r[PF_C]});
          p_nxt[PF_C] = m[7];
        end
        OP_ADC, OP_SBC: begin
          a_nxt = sum9[7:0];
          p_nxt = set_nz(p_r, sum9[7:0]);
          p_nxt[PF_C] = sum9[8];
          p_nxt[PF_V] = ~(a_r[7] ^ addend[7]) & (a_r[7] ^ sum9[7]);
        end
        OP_TXS: sp_nxt = x_r;
        OP_TSX: begin x_nxt = sp_r; p_nxt = set_nz(p_r, sp_r); end
        OP_PLA: begin a_nxt = m;    p_nxt = set_nz(p_r, m); end
        OP_PLP: p_nxt = m & P_MASK;
        OP_BR: begin
          if (br_taken) begin
            pc_nxt = pc_r + {{8{m[7]}}, m};
          end
        end
        OP_CMP, OP_CPX, OP_CPY: begin
          p_nxt = set_nz(p_r, diff9[7:0]);
          p_nxt[PF_C] = diff9[8];
        end
        OP_LDA: begin a_nxt = m; p_nxt = set_nz(p_r, m); end
        OP_LDX: begin x_nxt = m; p_nxt = set_nz(p_r, m); end
        OP_LDY: begin y_nxt = m; p_nxt = set_nz(p_r, m); end
        OP_CLC: p_nxt[PF_C] = 1'b0;
        OP_SEC: p_nxt[PF_C] = 1'b1;
        OP_CLI: p_nxt[PF_I] = 1'b0;
        OP_SEI: p_nxt[PF_I] = 1'b1;
        OP_CLV: p_nxt[PF_V] = 1'b0;
        OP_CLD: p_nxt[PF_D] = 1'b0;
        OP_SED: p_nxt[PF_D] = 1'b1;
        default: ;
      endcase
    end
  end

  // architectural registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= 16'h0000;
      a_r  <= 8'h00;
      x_r  <= 8'h00;
      y_r  <= 8'h00;
      sp_r <= SP_INIT;
      p_r  <= 8'h00;
    end else begin
      pc_r <= pc_nxt;
      a_r  <= a_nxt;
      x_r  <= x_nxt;
      y_r  <= y_nxt;
      sp_r <= sp_nxt;
      p_r  <= p_nxt;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    ea_r  <= ea_nxt;
    res_r <= res_nxt;
    if (cmd.op_load) begin
      op_r <= m;
    end
    if (cmd.ea_op == EA_LO) begin
      lo_r <= m;
    end
    if (cmd.host_load) begin
      host_addr_r <= in_host_addr;
      host_data_r <= in_host_data;
    end
    if (cmd.rdb_clr) begin
      rdb_r <= 8'h00;
    end else if (cmd.rdb_load) begin
      rdb_r <= m;
    end
    if (cmd.out_load) begin
      o_rd_r  <= rdb_r;
      o_pc_r  <= pc_r;
      o_a_r   <= a_r;
      o_x_r   <= x_r;
      o_y_r   <= y_r;
      o_sp_r  <= sp_r;
      o_p_r   <= p_r & P_MASK;
      o_bad_r <= cmd.bad_opc;
    end
  end

  assign out_read_data    = o_rd_r;
  assign out_pc_value     = o_pc_r;
  assign out_acc          = o_a_r;
  assign out_x_reg        = o_x_r;
  assign out_y_reg        = o_y_r;
  assign out_stack_ptr    = o_sp_r;
  assign out_status_flags = o_p_r;
  assign out_bad_opcode   = o_bad_r;

endmodule

@@ src/cpu8_ctrl.sv @@
module cpu8_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_command,
  output logic                out_valid,
  input  logic                out_stall,
  input  cpu8_pkg::ctl_stat_t stat,
  output cpu8_pkg::ctl_cmd_t  cmd
);
  import cpu8_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_HRD, S_VLO, S_VHI, S_OPC, S_DISP, S_OP1, S_OP2, S_JSR,
    S_PTR, S_PTR2, S_PTR3, S_EA, S_MEM, S_WB, S_PL1, S_PL2,
    S_RLO_RD, S_RLO, S_RHI_RD, S_RHI, S_DONE
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] cmd_r;
  logic       bad_r, bad_nxt, out_valid_r, accept;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '{AS_PC, 1'b0, WS_HOST, PC_KEEP, EA_KEEP, SP_KEEP,
                  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    cmd.bad_opc = bad_r;
    state_nxt = state_r;
    bad_nxt   = bad_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.host_load = 1'b1;
          bad_nxt       = 1'b0;
          state_nxt     = S_START;
        end
      end
      S_START: begin
        cmd.rdb_clr = 1'b1;
        unique case (cmd_r)
          CMD_WRITE: begin
            cmd.asel = AS_HOST; cmd.wsel = WS_HOST; cmd.mem_we = 1'b1;
            state_nxt = S_DONE;
          end
          CMD_READ: begin
            cmd.asel = AS_HOST; state_nxt = S_HRD;
          end
          CMD_RESET: begin
            cmd.asel = AS_VEC_LO; state_nxt = S_VLO;
          end
          default: begin
            cmd.asel = AS_PC; cmd.pc_op = PC_INC; state_nxt = S_OPC;
          end
        endcase
      end
      S_HRD: begin
        cmd.rdb_load = 1'b1; state_nxt = S_DONE;
      end
      S_VLO: begin
        cmd.ea_op = EA_LO; cmd.asel = AS_VEC_HI; state_nxt = S_VHI;
      end
      S_VHI: begin
        cmd.pc_op = PC_LOHI; cmd.sp_op = SP_RESET; cmd.vec_rst = 1'b1;
        state_nxt = S_DONE;
      end
      S_OPC: begin
        cmd.op_load = 1'b1; state_nxt = S_DISP;
      end
      S_DISP: begin
        priority case (stat.cls)
          CL_BAD:  begin bad_nxt = 1'b1; state_nxt = S_DONE; end
          CL_IMP:  begin cmd.exec = 1'b1; state_nxt = S_DONE; end
          CL_PUSH: begin
            cmd.asel = AS_STK; cmd.wsel = WS_PUSH; cmd.mem_we = 1'b1;
            cmd.sp_op = SP_DEC; state_nxt = S_DONE;
          end
          CL_PULL, CL_RTI: begin cmd.sp_op = SP_INC; state_nxt = S_PL1; end
          CL_RTS:  begin cmd.sp_op = SP_INC; state_nxt = S_RLO_RD; end
          default: begin
            cmd.asel = AS_PC; cmd.pc_op = PC_INC; state_nxt = S_OP1;
          end
        endcase
      end
      S_OP1: begin
        priority case (stat.mode)
          AM_IMM, AM_REL: begin cmd.exec = 1'b1; state_nxt = S_DONE; end
          AM_ZP:   begin cmd.ea_op = EA_ZP;  state_nxt = S_EA; end
          AM_ZPX:  begin cmd.ea_op = EA_ZPX; state_nxt = S_EA; end
          AM_INDX: begin cmd.ea_op = EA_ZPX; state_nxt = S_PTR; end
          AM_INDY: begin cmd.ea_op = EA_ZP;  state_nxt = S_PTR; end
          default: begin
            cmd.ea_op = EA_LO; cmd.asel = AS_PC; cmd.pc_op = PC_INC;
            state_nxt = S_OP2;
          end
        endcase
      end
      S_OP2: begin
        priority if (stat.cls == CL_JMP) begin
          cmd.pc_op = PC_LOHI; state_nxt = S_DONE;
        end else if (stat.cls == CL_JSR) begin
          cmd.ea_op = EA_ABS; cmd.asel = AS_STK; cmd.wsel = WS_PCH;
          cmd.mem_we = 1'b1; cmd.sp_op = SP_DEC; state_nxt = S_JSR;
        end else if (stat.cls == CL_JMPI) begin
          cmd.ea_op = EA_ABS; state_nxt = S_PTR;
        end else if (stat.mode == AM_ABSX) begin
          cmd.ea_op = EA_ABSX; state_nxt = S_EA;
        end else if (stat.mode == AM_ABSY) begin
          cmd.ea_op = EA_ABSY; state_nxt = S_EA;
        end else begin
          cmd.ea_op = EA_ABS; state_nxt = S_EA;
        end
      end
      S_JSR: begin
        cmd.asel = AS_STK; cmd.wsel = WS_PCL; cmd.mem_we = 1'b1;
        cmd.sp_op = SP_DEC; cmd.pc_op = PC_EA; state_nxt = S_DONE;
      end
      S_PTR: begin
        cmd.asel = AS_EA; state_nxt = S_PTR2;
      end
      S_PTR2: begin
        cmd.ea_op = EA_LO; cmd.asel = AS_EA_NEXT; state_nxt = S_PTR3;
      end
      S_PTR3: begin
        priority if (stat.cls == CL_JMPI) begin
          cmd.pc_op = PC_LOHI; state_nxt = S_DONE;
        end else if (stat.mode == AM_INDY) begin
          cmd.ea_op = EA_ABSY; state_nxt = S_EA;
        end else begin
          cmd.ea_op = EA_ABS; state_nxt = S_EA;
        end
      end
      S_EA: begin
        cmd.asel = AS_EA;
        if (stat.cls == CL_STORE) begin
          cmd.wsel = WS_STORE; cmd.mem_we = 1'b1; state_nxt = S_DONE;
        end else begin
          state_nxt = S_MEM;
        end
      end
      S_MEM: begin
        cmd.exec  = 1'b1;
        state_nxt = (stat.cls == CL_RMW) ? S_WB : S_DONE;
      end
      S_WB: begin
        cmd.asel = AS_EA; cmd.wsel = WS_RES; cmd.mem_we = 1'b1; state_nxt = S_DONE;
      end
      S_PL1: begin
        cmd.asel = AS_STK; state_nxt = S_PL2;
      end
      S_PL2: begin
        cmd.exec = 1'b1;
        if (stat.cls == CL_RTI) begin
          cmd.sp_op = SP_INC; state_nxt = S_RLO_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RLO_RD: begin
        cmd.asel = AS_STK; state_nxt = S_RLO;
      end
      S_RLO: begin
        cmd.ea_op = EA_LO; cmd.sp_op = SP_INC; state_nxt = S_RHI_RD;
      end
      S_RHI_RD: begin
        cmd.asel = AS_STK; state_nxt = S_RHI;
      end
      S_RHI: begin
        cmd.pc_op = (stat.cls == CL_RTS) ? PC_LOHI_INC : PC_LOHI;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmd_r       <= CMD_WRITE;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bad_r   <= bad_nxt;
      if (accept) begin
        cmd_r <= in_command;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !cmd.mem_we)
    else $error("memory write while idle");

  a_result_not_overwritten: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while held");

  a_accept_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !cmd.out_load)
    else $error("result loaded in cycle after accept");

  a_bad_only_on_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && bad_r) |-> (cmd_r == CMD_STEP))
    else $error("bad opcode flagged on host request");

endmodule
